// ===== rtl/mcc_pkg.sv =====
// shared types, constants and codes for the motor converter conditioning block
package mcc_pkg;

	localparam int DATA_W = 32;
	localparam int ADC_W = 12;
	localparam int COEF_W = 25;
	localparam int FLAG_N = 21;
	localparam int FLAG_W = 5;
	localparam int TMP_DEPTH = 22;
	localparam int TMP_W = 5;
	localparam int PC_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W = 24;

	// fixed-point constants in Q24
	localparam logic [DATA_W-1:0] C_CENTRE = 32'd8388607;
	localparam logic [DATA_W-1:0] C_ONE = 32'd16777216;
	localparam logic [DATA_W-1:0] C_TWO = 32'd33554432;
	localparam logic [DATA_W-1:0] C_INV_SQRT3 = 32'd9686330;
	localparam logic [DATA_W-1:0] C_THIRD_POS = 32'd5592405;
	localparam logic [DATA_W-1:0] C_THIRD_NEG = 32'hFFAA_AAAB;
	localparam logic [DATA_W-1:0] C_MINUS_ONE = 32'hFF00_0000;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_AVG_COEFF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CUR_U = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CUR_V = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CUR_W = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_VOLT_AB = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_VOLT_BC = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DC_BUS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_DC_BUS = 3'd7;

	localparam logic [COEF_W-1:0] AVG_COEFF_RST = 25'd16609444;

	// alarm bit positions
	localparam logic [FLAG_W-1:0] FB_DC_UNDER = 5'd16;
	localparam logic [FLAG_W-1:0] FB_DC_OVER = 5'd17;
	localparam logic [FLAG_W-1:0] FB_VOLT_U = 5'd2;
	localparam logic [FLAG_W-1:0] FB_VOLT_V = 5'd3;
	localparam logic [FLAG_W-1:0] FB_VOLT_W = 5'd4;
	localparam logic [FLAG_W-1:0] FB_CUR_U = 5'd18;
	localparam logic [FLAG_W-1:0] FB_CUR_V = 5'd19;
	localparam logic [FLAG_W-1:0] FB_CUR_W = 5'd20;
	localparam logic [FLAG_W-1:0] FB_NONE = 5'd0;

	// scratch register slots; the first five hold the running means
	localparam logic [TMP_W-1:0] T_MCU = 5'd0;
	localparam logic [TMP_W-1:0] T_MCV = 5'd1;
	localparam logic [TMP_W-1:0] T_MCW = 5'd2;
	localparam logic [TMP_W-1:0] T_MAB = 5'd3;
	localparam logic [TMP_W-1:0] T_MBC = 5'd4;
	localparam logic [TMP_W-1:0] T_OMK = 5'd5;
	localparam logic [TMP_W-1:0] T_TMK = 5'd6;
	localparam logic [TMP_W-1:0] T_IU = 5'd7;
	localparam logic [TMP_W-1:0] T_IV = 5'd8;
	localparam logic [TMP_W-1:0] T_IW = 5'd9;
	localparam logic [TMP_W-1:0] T_VAB = 5'd10;
	localparam logic [TMP_W-1:0] T_VBC = 5'd11;
	localparam logic [TMP_W-1:0] T_TMP = 5'd12;
	localparam logic [TMP_W-1:0] T_IA = 5'd13;
	localparam logic [TMP_W-1:0] T_UU = 5'd14;
	localparam logic [TMP_W-1:0] T_UV = 5'd15;
	localparam logic [TMP_W-1:0] T_IB = 5'd16;
	localparam logic [TMP_W-1:0] T_DAB = 5'd17;
	localparam logic [TMP_W-1:0] T_DBC = 5'd18;
	localparam logic [TMP_W-1:0] T_UW = 5'd19;
	localparam logic [TMP_W-1:0] T_UB = 5'd20;
	localparam logic [TMP_W-1:0] T_DC = 5'd21;

	localparam logic [PC_W-1:0] PC_START = 7'd0;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LD,
		OP_ADD,
		OP_SUB,
		OP_SHL1,
		OP_MUL,
		OP_FLT,
		OP_FGT,
		OP_MGT,
		OP_MGE
	} op_t;

	typedef enum logic [4:0] {
		SRC_TMP,
		SRC_COEF,
		SRC_GAIN_CU,
		SRC_GAIN_CV,
		SRC_GAIN_CW,
		SRC_GAIN_VAB,
		SRC_GAIN_VBC,
		SRC_GAIN_DC,
		SRC_OFFS_DC,
		SRC_ADC_CU,
		SRC_ADC_CV,
		SRC_ADC_CW,
		SRC_ADC_VAB,
		SRC_ADC_VBC,
		SRC_ADC_DC,
		SRC_LIM_DCMIN,
		SRC_LIM_DCMAX,
		SRC_LIM_ACV,
		SRC_LIM_ACC,
		SRC_C_CENTRE,
		SRC_C_ONE,
		SRC_C_TWO,
		SRC_C_INVS3,
		SRC_C_THIRD_POS,
		SRC_C_THIRD_NEG,
		SRC_C_MINUS_ONE
	} src_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_WAIT_IN,
		BR_EMIT
	} br_t;

	typedef struct packed {
		op_t op;
		src_t src;
		logic [TMP_W-1:0] ridx;
		logic st;
		logic [TMP_W-1:0] widx;
		logic [FLAG_W-1:0] fbit;
		br_t br;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_rdy;
		logic in_take;
		logic out_load;
	} seq_stat_t;

	typedef struct packed {
		logic [COEF_W-1:0] avg_coeff;
		logic signed [DATA_W-1:0] gain_cur_u;
		logic signed [DATA_W-1:0] gain_cur_v;
		logic signed [DATA_W-1:0] gain_cur_w;
		logic signed [DATA_W-1:0] gain_volt_ab;
		logic signed [DATA_W-1:0] gain_volt_bc;
		logic signed [DATA_W-1:0] gain_dc_bus;
		logic signed [DATA_W-1:0] offset_dc_bus;
	} cfg_t;

	typedef struct packed {
		logic [ADC_W-1:0] adc_cur_u;
		logic [ADC_W-1:0] adc_cur_v;
		logic [ADC_W-1:0] adc_cur_w;
		logic [ADC_W-1:0] adc_volt_ab;
		logic [ADC_W-1:0] adc_volt_bc;
		logic [ADC_W-1:0] adc_dc_bus;
		logic signed [DATA_W-1:0] dc_min_limit;
		logic signed [DATA_W-1:0] dc_max_limit;
		logic signed [DATA_W-1:0] ac_volt_limit;
		logic signed [DATA_W-1:0] ac_cur_limit;
	} smp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] cur_alpha;
		logic signed [DATA_W-1:0] cur_beta;
		logic signed [DATA_W-1:0] volt_alpha;
		logic signed [DATA_W-1:0] volt_beta;
		logic signed [DATA_W-1:0] dc_bus_volt;
		logic [FLAG_N-1:0] alarm_flags;
		logic signed [DATA_W-1:0] mean_cur_u_out;
		logic signed [DATA_W-1:0] mean_cur_v_out;
		logic signed [DATA_W-1:0] mean_cur_w_out;
		logic signed [DATA_W-1:0] mean_volt_ab_out;
		logic signed [DATA_W-1:0] mean_volt_bc_out;
	} res_t;

endpackage

// ===== rtl/mcc_in_if.sv =====
// sample set channel: valid, ready and the converter codes with alarm limits
interface mcc_in_if;
	logic valid;
	logic ready;
	logic [mcc_pkg::ADC_W-1:0] adc_cur_u;
	logic [mcc_pkg::ADC_W-1:0] adc_cur_v;
	logic [mcc_pkg::ADC_W-1:0] adc_cur_w;
	logic [mcc_pkg::ADC_W-1:0] adc_volt_ab;
	logic [mcc_pkg::ADC_W-1:0] adc_volt_bc;
	logic [mcc_pkg::ADC_W-1:0] adc_dc_bus;
	logic signed [mcc_pkg::DATA_W-1:0] dc_min_limit;
	logic signed [mcc_pkg::DATA_W-1:0] dc_max_limit;
	logic signed [mcc_pkg::DATA_W-1:0] ac_volt_limit;
	logic signed [mcc_pkg::DATA_W-1:0] ac_cur_limit;

	modport source (
		output valid, adc_cur_u, adc_cur_v, adc_cur_w, adc_volt_ab, adc_volt_bc,
		output adc_dc_bus, dc_min_limit, dc_max_limit, ac_volt_limit, ac_cur_limit,
		input ready
	);
	modport sink (
		input valid, adc_cur_u, adc_cur_v, adc_cur_w, adc_volt_ab, adc_volt_bc,
		input adc_dc_bus, dc_min_limit, dc_max_limit, ac_volt_limit, ac_cur_limit,
		output ready
	);
endinterface

// ===== rtl/mcc_out_if.sv =====
// result channel: valid, ready and the conditioned values with alarm flags
interface mcc_out_if;
	logic valid;
	logic ready;
	logic signed [mcc_pkg::DATA_W-1:0] cur_alpha;
	logic signed [mcc_pkg::DATA_W-1:0] cur_beta;
	logic signed [mcc_pkg::DATA_W-1:0] volt_alpha;
	logic signed [mcc_pkg::DATA_W-1:0] volt_beta;
	logic signed [mcc_pkg::DATA_W-1:0] dc_bus_volt;
	logic [mcc_pkg::FLAG_N-1:0] alarm_flags;
	logic signed [mcc_pkg::DATA_W-1:0] mean_cur_u_out;
	logic signed [mcc_pkg::DATA_W-1:0] mean_cur_v_out;
	logic signed [mcc_pkg::DATA_W-1:0] mean_cur_w_out;
	logic signed [mcc_pkg::DATA_W-1:0] mean_volt_ab_out;
	logic signed [mcc_pkg::DATA_W-1:0] mean_volt_bc_out;

	modport source (
		output valid, cur_alpha, cur_beta, volt_alpha, volt_beta, dc_bus_volt,
		output alarm_flags, mean_cur_u_out, mean_cur_v_out, mean_cur_w_out,
		output mean_volt_ab_out, mean_volt_bc_out,
		input ready
	);
	modport sink (
		input valid, cur_alpha, cur_beta, volt_alpha, volt_beta, dc_bus_volt,
		input alarm_flags, mean_cur_u_out, mean_cur_v_out, mean_cur_w_out,
		input mean_volt_ab_out, mean_volt_bc_out,
		output ready
	);
endinterface

// ===== rtl/mcc_ucode.sv =====
// program store and step counter that issue one control word per cycle, stalling at the wait and emit steps
module mcc_ucode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_free,
	output mcc_pkg::ctrl_t      ctrl,
	output mcc_pkg::seq_stat_t  stat
);

	logic [mcc_pkg::PC_W-1:0] pc_q;
	logic [mcc_pkg::PC_W-1:0] pc_d;

	function automatic mcc_pkg::ctrl_t uop(
		input mcc_pkg::op_t op,
		input mcc_pkg::src_t src,
		input logic [mcc_pkg::TMP_W-1:0] ridx,
		input logic st,
		input logic [mcc_pkg::TMP_W-1:0] widx,
		input logic [mcc_pkg::FLAG_W-1:0] fbit,
		input mcc_pkg::br_t br
	);
		mcc_pkg::ctrl_t w;
		w.op = op;
		w.src = src;
		w.ridx = ridx;
		w.st = st;
		w.widx = widx;
		w.fbit = fbit;
		w.br = br;
		w.target = mcc_pkg::PC_START;
		return w;
	endfunction

	// plain step: operand from a source, optional store
	function automatic mcc_pkg::ctrl_t ex(
		input mcc_pkg::op_t op,
		input mcc_pkg::src_t src,
		input logic st,
		input logic [mcc_pkg::TMP_W-1:0] widx
	);
		return uop(op, src, mcc_pkg::T_MCU, st, widx, mcc_pkg::FB_NONE, mcc_pkg::BR_NEXT);
	endfunction

	// step with a scratch register operand
	function automatic mcc_pkg::ctrl_t ext(
		input mcc_pkg::op_t op,
		input logic [mcc_pkg::TMP_W-1:0] ridx,
		input logic st,
		input logic [mcc_pkg::TMP_W-1:0] widx
	);
		return uop(op, mcc_pkg::SRC_TMP, ridx, st, widx, mcc_pkg::FB_NONE,
			mcc_pkg::BR_NEXT);
	endfunction

	// alarm compare of the accumulator
	function automatic mcc_pkg::ctrl_t fl(
		input mcc_pkg::op_t op,
		input mcc_pkg::src_t src,
		input logic [mcc_pkg::FLAG_W-1:0] fbit
	);
		return uop(op, src, mcc_pkg::T_MCU, 1'b0, mcc_pkg::T_MCU, fbit, mcc_pkg::BR_NEXT);
	endfunction

	always_comb begin
		ctrl = uop(mcc_pkg::OP_NOP, mcc_pkg::SRC_TMP, mcc_pkg::T_MCU, 1'b0, mcc_pkg::T_MCU,
			mcc_pkg::FB_NONE, mcc_pkg::BR_EMIT);
		case (pc_q)
			7'd0: ctrl = uop(mcc_pkg::OP_NOP, mcc_pkg::SRC_TMP, mcc_pkg::T_MCU, 1'b0,
				mcc_pkg::T_MCU, mcc_pkg::FB_NONE, mcc_pkg::BR_WAIT_IN);
			// 1 - k and 2 - k
			7'd1: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_C_ONE, 1'b0, mcc_pkg::T_MCU);
			7'd2: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_COEF, 1'b1, mcc_pkg::T_OMK);
			7'd3: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_C_TWO, 1'b0, mcc_pkg::T_MCU);
			7'd4: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_COEF, 1'b1, mcc_pkg::T_TMK);
			// centre and scale each sample
			7'd5: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_ADC_CU, 1'b0, mcc_pkg::T_MCU);
			7'd6: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_C_CENTRE, 1'b0, mcc_pkg::T_MCU);
			7'd7: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_GAIN_CU, 1'b1, mcc_pkg::T_IU);
			7'd8: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_ADC_CV, 1'b0, mcc_pkg::T_MCU);
			7'd9: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_C_CENTRE, 1'b0, mcc_pkg::T_MCU);
			7'd10: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_GAIN_CV, 1'b1, mcc_pkg::T_IV);
			7'd11: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_ADC_CW, 1'b0, mcc_pkg::T_MCU);
			7'd12: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_C_CENTRE, 1'b0, mcc_pkg::T_MCU);
			7'd13: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_GAIN_CW, 1'b1, mcc_pkg::T_IW);
			7'd14: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_ADC_VAB, 1'b0, mcc_pkg::T_MCU);
			7'd15: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_C_CENTRE, 1'b0, mcc_pkg::T_MCU);
			7'd16: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_GAIN_VAB, 1'b1, mcc_pkg::T_VAB);
			7'd17: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_ADC_VBC, 1'b0, mcc_pkg::T_MCU);
			7'd18: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_C_CENTRE, 1'b0, mcc_pkg::T_MCU);
			7'd19: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_GAIN_VBC, 1'b1, mcc_pkg::T_VBC);
			// current means: mean*k + sample*(1-k)
			7'd20: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_IU, 1'b0, mcc_pkg::T_MCU);
			7'd21: ctrl = ext(mcc_pkg::OP_MUL, mcc_pkg::T_OMK, 1'b1, mcc_pkg::T_TMP);
			7'd22: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_MCU, 1'b0, mcc_pkg::T_MCU);
			7'd23: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_COEF, 1'b0, mcc_pkg::T_MCU);
			7'd24: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_TMP, 1'b1, mcc_pkg::T_MCU);
			7'd25: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_IV, 1'b0, mcc_pkg::T_MCU);
			7'd26: ctrl = ext(mcc_pkg::OP_MUL, mcc_pkg::T_OMK, 1'b1, mcc_pkg::T_TMP);
			7'd27: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_MCV, 1'b0, mcc_pkg::T_MCU);
			7'd28: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_COEF, 1'b0, mcc_pkg::T_MCU);
			7'd29: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_TMP, 1'b1, mcc_pkg::T_MCV);
			7'd30: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_IW, 1'b0, mcc_pkg::T_MCU);
			7'd31: ctrl = ext(mcc_pkg::OP_MUL, mcc_pkg::T_OMK, 1'b1, mcc_pkg::T_TMP);
			7'd32: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_MCW, 1'b0, mcc_pkg::T_MCU);
			7'd33: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_COEF, 1'b0, mcc_pkg::T_MCU);
			7'd34: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_TMP, 1'b1, mcc_pkg::T_MCW);
			// current alpha and beta
			7'd35: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_TMK, 1'b0, mcc_pkg::T_MCU);
			7'd36: ctrl = ext(mcc_pkg::OP_MUL, mcc_pkg::T_IU, 1'b0, mcc_pkg::T_MCU);
			7'd37: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_MCU, 1'b1, mcc_pkg::T_IA);
			7'd38: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_TMK, 1'b0, mcc_pkg::T_MCU);
			7'd39: ctrl = ext(mcc_pkg::OP_MUL, mcc_pkg::T_IV, 1'b0, mcc_pkg::T_MCU);
			7'd40: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_MCV, 1'b0, mcc_pkg::T_MCU);
			7'd41: ctrl = ext(mcc_pkg::OP_SHL1, mcc_pkg::T_MCU, 1'b0, mcc_pkg::T_MCU);
			7'd42: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_IA, 1'b0, mcc_pkg::T_MCU);
			7'd43: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_C_INVS3, 1'b1, mcc_pkg::T_IB);
			// voltage deltas against the previous means
			7'd44: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_VAB, 1'b0, mcc_pkg::T_MCU);
			7'd45: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_MAB, 1'b1, mcc_pkg::T_DAB);
			7'd46: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_VBC, 1'b0, mcc_pkg::T_MCU);
			7'd47: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_MBC, 1'b1, mcc_pkg::T_DBC);
			// phase voltages
			7'd48: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_DAB, 1'b0, mcc_pkg::T_MCU);
			7'd49: ctrl = ext(mcc_pkg::OP_SHL1, mcc_pkg::T_MCU, 1'b0, mcc_pkg::T_MCU);
			7'd50: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_DBC, 1'b0, mcc_pkg::T_MCU);
			7'd51: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_C_THIRD_NEG, 1'b1, mcc_pkg::T_UU);
			7'd52: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_DAB, 1'b0, mcc_pkg::T_MCU);
			7'd53: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_DBC, 1'b0, mcc_pkg::T_MCU);
			7'd54: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_C_THIRD_POS, 1'b1, mcc_pkg::T_UV);
			// accumulator still holds uv
			7'd55: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_UU, 1'b0, mcc_pkg::T_MCU);
			7'd56: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_C_MINUS_ONE, 1'b1, mcc_pkg::T_UW);
			// voltage means, after the deltas used the old ones
			7'd57: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_VAB, 1'b0, mcc_pkg::T_MCU);
			7'd58: ctrl = ext(mcc_pkg::OP_MUL, mcc_pkg::T_OMK, 1'b1, mcc_pkg::T_TMP);
			7'd59: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_MAB, 1'b0, mcc_pkg::T_MCU);
			7'd60: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_COEF, 1'b0, mcc_pkg::T_MCU);
			7'd61: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_TMP, 1'b1, mcc_pkg::T_MAB);
			7'd62: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_VBC, 1'b0, mcc_pkg::T_MCU);
			7'd63: ctrl = ext(mcc_pkg::OP_MUL, mcc_pkg::T_OMK, 1'b1, mcc_pkg::T_TMP);
			7'd64: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_MBC, 1'b0, mcc_pkg::T_MCU);
			7'd65: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_COEF, 1'b0, mcc_pkg::T_MCU);
			7'd66: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_TMP, 1'b1, mcc_pkg::T_MBC);
			// voltage beta
			7'd67: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_UV, 1'b0, mcc_pkg::T_MCU);
			7'd68: ctrl = ext(mcc_pkg::OP_SHL1, mcc_pkg::T_MCU, 1'b0, mcc_pkg::T_MCU);
			7'd69: ctrl = ext(mcc_pkg::OP_ADD, mcc_pkg::T_UU, 1'b0, mcc_pkg::T_MCU);
			7'd70: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_C_INVS3, 1'b1, mcc_pkg::T_UB);
			// dc bus
			7'd71: ctrl = ex(mcc_pkg::OP_LD, mcc_pkg::SRC_ADC_DC, 1'b0, mcc_pkg::T_MCU);
			7'd72: ctrl = ex(mcc_pkg::OP_SUB, mcc_pkg::SRC_OFFS_DC, 1'b0, mcc_pkg::T_MCU);
			7'd73: ctrl = ex(mcc_pkg::OP_MUL, mcc_pkg::SRC_GAIN_DC, 1'b1, mcc_pkg::T_DC);
			// alarms
			7'd74: ctrl = fl(mcc_pkg::OP_FLT, mcc_pkg::SRC_LIM_DCMIN, mcc_pkg::FB_DC_UNDER);
			7'd75: ctrl = fl(mcc_pkg::OP_FGT, mcc_pkg::SRC_LIM_DCMAX, mcc_pkg::FB_DC_OVER);
			7'd76: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_UU, 1'b0, mcc_pkg::T_MCU);
			7'd77: ctrl = fl(mcc_pkg::OP_MGT, mcc_pkg::SRC_LIM_ACV, mcc_pkg::FB_VOLT_U);
			7'd78: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_UV, 1'b0, mcc_pkg::T_MCU);
			7'd79: ctrl = fl(mcc_pkg::OP_MGT, mcc_pkg::SRC_LIM_ACV, mcc_pkg::FB_VOLT_V);
			7'd80: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_UW, 1'b0, mcc_pkg::T_MCU);
			7'd81: ctrl = fl(mcc_pkg::OP_MGT, mcc_pkg::SRC_LIM_ACV, mcc_pkg::FB_VOLT_W);
			7'd82: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_IU, 1'b0, mcc_pkg::T_MCU);
			7'd83: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_MCU, 1'b0, mcc_pkg::T_MCU);
			7'd84: ctrl = fl(mcc_pkg::OP_MGE, mcc_pkg::SRC_LIM_ACC, mcc_pkg::FB_CUR_U);
			7'd85: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_IV, 1'b0, mcc_pkg::T_MCU);
			7'd86: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_MCV, 1'b0, mcc_pkg::T_MCU);
			7'd87: ctrl = fl(mcc_pkg::OP_MGE, mcc_pkg::SRC_LIM_ACC, mcc_pkg::FB_CUR_V);
			7'd88: ctrl = ext(mcc_pkg::OP_LD, mcc_pkg::T_IW, 1'b0, mcc_pkg::T_MCU);
			7'd89: ctrl = ext(mcc_pkg::OP_SUB, mcc_pkg::T_MCW, 1'b0, mcc_pkg::T_MCU);
			7'd90: ctrl = fl(mcc_pkg::OP_MGE, mcc_pkg::SRC_LIM_ACC, mcc_pkg::FB_CUR_W);
			// last step: hand the result over, then back to the wait step
			default: ctrl = uop(mcc_pkg::OP_NOP, mcc_pkg::SRC_TMP, mcc_pkg::T_MCU, 1'b0,
				mcc_pkg::T_MCU, mcc_pkg::FB_NONE, mcc_pkg::BR_EMIT);
		endcase
	end

	always_comb begin
		pc_d = pc_q + 1'b1;
		stat.in_rdy = 1'b0;
		stat.in_take = 1'b0;
		stat.out_load = 1'b0;
		case (ctrl.br)
			mcc_pkg::BR_WAIT_IN: begin
				stat.in_rdy = 1'b1;
				stat.in_take = in_valid;
				if (!in_valid) pc_d = pc_q;
			end
			mcc_pkg::BR_EMIT: begin
				stat.out_load = out_free;
				pc_d = out_free ? ctrl.target : pc_q;
			end
			default: pc_d = pc_q + 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pc_q <= mcc_pkg::PC_START;
		else pc_q <= pc_d;
	end

endmodule

// ===== rtl/mcc_datapath.sv =====
// accumulator datapath: operand select, shared q24 multiplier, scratch registers, alarms
module mcc_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  mcc_pkg::ctrl_t  ctrl,
	input  logic            clr_flags,
	input  mcc_pkg::cfg_t   cfg,
	input  mcc_pkg::smp_t   smp,
	output mcc_pkg::res_t   res
);

	logic signed [mcc_pkg::DATA_W-1:0] acc_q;
	logic signed [mcc_pkg::DATA_W-1:0] tmp_q [mcc_pkg::TMP_DEPTH];
	logic [mcc_pkg::FLAG_N-1:0] flags_q;
	logic signed [mcc_pkg::DATA_W-1:0] opb;
	logic signed [mcc_pkg::DATA_W-1:0] alu;
	logic signed [2*mcc_pkg::DATA_W-1:0] prod;
	logic signed [mcc_pkg::DATA_W+1:0] mag;
	logic signed [mcc_pkg::DATA_W+1:0] opb_x;
	logic cmp;
	logic acc_we;

	function automatic logic [mcc_pkg::DATA_W-1:0] adc_word(input logic [mcc_pkg::ADC_W-1:0] c);
		return {{(mcc_pkg::DATA_W-2*mcc_pkg::ADC_W){1'b0}}, c, {mcc_pkg::ADC_W{1'b0}}};
	endfunction

	always_comb begin
		case (ctrl.src)
			mcc_pkg::SRC_TMP: opb = tmp_q[ctrl.ridx];
			mcc_pkg::SRC_COEF: opb = {{(mcc_pkg::DATA_W-mcc_pkg::COEF_W){1'b0}}, cfg.avg_coeff};
			mcc_pkg::SRC_GAIN_CU: opb = cfg.gain_cur_u;
			mcc_pkg::SRC_GAIN_CV: opb = cfg.gain_cur_v;
			mcc_pkg::SRC_GAIN_CW: opb = cfg.gain_cur_w;
			mcc_pkg::SRC_GAIN_VAB: opb = cfg.gain_volt_ab;
			mcc_pkg::SRC_GAIN_VBC: opb = cfg.gain_volt_bc;
			mcc_pkg::SRC_GAIN_DC: opb = cfg.gain_dc_bus;
			mcc_pkg::SRC_OFFS_DC: opb = cfg.offset_dc_bus;
			mcc_pkg::SRC_ADC_CU: opb = adc_word(smp.adc_cur_u);
			mcc_pkg::SRC_ADC_CV: opb = adc_word(smp.adc_cur_v);
			mcc_pkg::SRC_ADC_CW: opb = adc_word(smp.adc_cur_w);
			mcc_pkg::SRC_ADC_VAB: opb = adc_word(smp.adc_volt_ab);
			mcc_pkg::SRC_ADC_VBC: opb = adc_word(smp.adc_volt_bc);
			mcc_pkg::SRC_ADC_DC: opb = adc_word(smp.adc_dc_bus);
			mcc_pkg::SRC_LIM_DCMIN: opb = smp.dc_min_limit;
			mcc_pkg::SRC_LIM_DCMAX: opb = smp.dc_max_limit;
			mcc_pkg::SRC_LIM_ACV: opb = smp.ac_volt_limit;
			mcc_pkg::SRC_LIM_ACC: opb = smp.ac_cur_limit;
			mcc_pkg::SRC_C_CENTRE: opb = mcc_pkg::C_CENTRE;
			mcc_pkg::SRC_C_ONE: opb = mcc_pkg::C_ONE;
			mcc_pkg::SRC_C_TWO: opb = mcc_pkg::C_TWO;
			mcc_pkg::SRC_C_INVS3: opb = mcc_pkg::C_INV_SQRT3;
			mcc_pkg::SRC_C_THIRD_POS: opb = mcc_pkg::C_THIRD_POS;
			mcc_pkg::SRC_C_THIRD_NEG: opb = mcc_pkg::C_THIRD_NEG;
			mcc_pkg::SRC_C_MINUS_ONE: opb = mcc_pkg::C_MINUS_ONE;
			default: opb = '0;
		endcase
	end

	// floor shift by 24 of the 64-bit product, wrapped to 32 bits
	assign prod = acc_q * opb;

	// magnitude taken wide so the most negative value stays exact
	assign mag = acc_q[mcc_pkg::DATA_W-1] ? -{{2{acc_q[mcc_pkg::DATA_W-1]}}, acc_q}
		: {2'b00, acc_q};
	assign opb_x = {{2{opb[mcc_pkg::DATA_W-1]}}, opb};

	always_comb begin
		alu = acc_q;
		acc_we = 1'b1;
		cmp = 1'b0;
		case (ctrl.op)
			mcc_pkg::OP_LD: alu = opb;
			mcc_pkg::OP_ADD: alu = acc_q + opb;
			mcc_pkg::OP_SUB: alu = acc_q - opb;
			mcc_pkg::OP_SHL1: alu = {acc_q[mcc_pkg::DATA_W-2:0], 1'b0};
			mcc_pkg::OP_MUL: alu = prod[mcc_pkg::DATA_W+mcc_pkg::FRAC_W-1:mcc_pkg::FRAC_W];
			mcc_pkg::OP_FLT: begin
				acc_we = 1'b0;
				cmp = acc_q < opb;
			end
			mcc_pkg::OP_FGT: begin
				acc_we = 1'b0;
				cmp = acc_q > opb;
			end
			mcc_pkg::OP_MGT: begin
				acc_we = 1'b0;
				cmp = mag > opb_x;
			end
			mcc_pkg::OP_MGE: begin
				acc_we = 1'b0;
				cmp = mag >= opb_x;
			end
			default: acc_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_q <= alu;
	end

	// scratch file; the running means live here and reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcc_pkg::TMP_DEPTH; i++) tmp_q[i] <= '0;
		end else if (ctrl.st && acc_we) begin
			tmp_q[ctrl.widx] <= alu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr_flags) begin
			flags_q <= '0;
		end else if (ctrl.op == mcc_pkg::OP_FLT || ctrl.op == mcc_pkg::OP_FGT ||
				ctrl.op == mcc_pkg::OP_MGT || ctrl.op == mcc_pkg::OP_MGE) begin
			flags_q[ctrl.fbit] <= cmp;
		end
	end

	always_comb begin
		res.cur_alpha = tmp_q[mcc_pkg::T_IA];
		res.cur_beta = tmp_q[mcc_pkg::T_IB];
		res.volt_alpha = tmp_q[mcc_pkg::T_UU];
		res.volt_beta = tmp_q[mcc_pkg::T_UB];
		res.dc_bus_volt = tmp_q[mcc_pkg::T_DC];
		res.alarm_flags = flags_q;
		res.mean_cur_u_out = tmp_q[mcc_pkg::T_MCU];
		res.mean_cur_v_out = tmp_q[mcc_pkg::T_MCV];
		res.mean_cur_w_out = tmp_q[mcc_pkg::T_MCW];
		res.mean_volt_ab_out = tmp_q[mcc_pkg::T_MAB];
		res.mean_volt_bc_out = tmp_q[mcc_pkg::T_MBC];
	end

endmodule

// ===== rtl/motor_adc_condition_clarke.sv =====
// Converter sample conditioning with running-mean offset removal and Clarke transform.
// A 92-step control program runs one step per cycle, holding at its wait step until a set
// arrives and at its emit step while the output register is not free, on an accumulator
// datapath with a single shared 32x32 Q24 multiplier. A new set is accepted at the wait step
// even while the previous result still waits in the output register. Configuration registers
// are written via cfg_we/cfg_index/cfg_wdata; the user must write only while idle, not enforced.
module motor_adc_condition_clarke (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcc_pkg::DATA_W-1:0]        cfg_wdata,
	mcc_in_if.sink                            sample,
	mcc_out_if.source                         result
);

	mcc_pkg::cfg_t cfg_q;
	mcc_pkg::smp_t smp_q;
	mcc_pkg::res_t res;
	mcc_pkg::res_t res_q;
	mcc_pkg::ctrl_t ctrl;
	mcc_pkg::seq_stat_t stat;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || result.ready;
	assign sample.ready = stat.in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.avg_coeff <= mcc_pkg::AVG_COEFF_RST;
			cfg_q.gain_cur_u <= mcc_pkg::C_ONE;
			cfg_q.gain_cur_v <= mcc_pkg::C_ONE;
			cfg_q.gain_cur_w <= mcc_pkg::C_ONE;
			cfg_q.gain_volt_ab <= mcc_pkg::C_ONE;
			cfg_q.gain_volt_bc <= mcc_pkg::C_ONE;
			cfg_q.gain_dc_bus <= mcc_pkg::C_ONE;
			cfg_q.offset_dc_bus <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mcc_pkg::CFG_AVG_COEFF: cfg_q.avg_coeff <= cfg_wdata[mcc_pkg::COEF_W-1:0];
				mcc_pkg::CFG_GAIN_CUR_U: cfg_q.gain_cur_u <= cfg_wdata;
				mcc_pkg::CFG_GAIN_CUR_V: cfg_q.gain_cur_v <= cfg_wdata;
				mcc_pkg::CFG_GAIN_CUR_W: cfg_q.gain_cur_w <= cfg_wdata;
				mcc_pkg::CFG_GAIN_VOLT_AB: cfg_q.gain_volt_ab <= cfg_wdata;
				mcc_pkg::CFG_GAIN_VOLT_BC: cfg_q.gain_volt_bc <= cfg_wdata;
				mcc_pkg::CFG_GAIN_DC_BUS: cfg_q.gain_dc_bus <= cfg_wdata;
				mcc_pkg::CFG_OFFSET_DC_BUS: cfg_q.offset_dc_bus <= cfg_wdata;
				default: cfg_q.offset_dc_bus <= cfg_q.offset_dc_bus;
			endcase
		end
	end

	// capture the sample set on the input transaction
	always_ff @(posedge clk) begin
		if (stat.in_take) begin
			smp_q.adc_cur_u <= sample.adc_cur_u;
			smp_q.adc_cur_v <= sample.adc_cur_v;
			smp_q.adc_cur_w <= sample.adc_cur_w;
			smp_q.adc_volt_ab <= sample.adc_volt_ab;
			smp_q.adc_volt_bc <= sample.adc_volt_bc;
			smp_q.adc_dc_bus <= sample.adc_dc_bus;
			smp_q.dc_min_limit <= sample.dc_min_limit;
			smp_q.dc_max_limit <= sample.dc_max_limit;
			smp_q.ac_volt_limit <= sample.ac_volt_limit;
			smp_q.ac_cur_limit <= sample.ac_cur_limit;
		end
	end

	mcc_ucode u_ucode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.out_free (out_free),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	mcc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.clr_flags (stat.in_take),
		.cfg       (cfg_q),
		.smp       (smp_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (stat.out_load) out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (stat.out_load) res_q <= res;
	end

	assign result.valid = out_valid_q;
	assign result.cur_alpha = res_q.cur_alpha;
	assign result.cur_beta = res_q.cur_beta;
	assign result.volt_alpha = res_q.volt_alpha;
	assign result.volt_beta = res_q.volt_beta;
	assign result.dc_bus_volt = res_q.dc_bus_volt;
	assign result.alarm_flags = res_q.alarm_flags;
	assign result.mean_cur_u_out = res_q.mean_cur_u_out;
	assign result.mean_cur_v_out = res_q.mean_cur_v_out;
	assign result.mean_cur_w_out = res_q.mean_cur_w_out;
	assign result.mean_volt_ab_out = res_q.mean_volt_ab_out;
	assign result.mean_volt_bc_out = res_q.mean_volt_bc_out;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the motor converter conditioning block
`timescale 1ns / 1ps

module testbench;
	import mcc_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int LATENCY_PAD = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_ITEMS = 113;
	localparam int CODE_MAX = (1 << ADC_W) - 1;
	localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

	class conditioning_scoreboard;
		cfg_t regs;
		logic [DATA_W-1:0] mean_iu, mean_iv, mean_iw, mean_ab, mean_bc;
		res_t pending[$];
		int mismatches;

		function new();
			regs.avg_coeff = AVG_COEFF_RST;
			regs.gain_cur_u = C_ONE;
			regs.gain_cur_v = C_ONE;
			regs.gain_cur_w = C_ONE;
			regs.gain_volt_ab = C_ONE;
			regs.gain_volt_bc = C_ONE;
			regs.gain_dc_bus = C_ONE;
			regs.offset_dc_bus = '0;
			mean_iu = '0;
			mean_iv = '0;
			mean_iw = '0;
			mean_ab = '0;
			mean_bc = '0;
			mismatches = 0;
		endfunction

		// signed Q24 product, floor shift, wrapped to 32 bits
		function logic [DATA_W-1:0] qmul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			longint prod;
			prod = longint'($signed(a)) * longint'($signed(b));
			prod = prod >>> FRAC_W;
			return prod[DATA_W-1:0];
		endfunction

		// exact magnitude, so the most negative value reads as 2^31
		function longint magnitude(logic [DATA_W-1:0] x);
			longint v;
			v = longint'($signed(x));
			return (v < 0) ? -v : v;
		endfunction

		function logic [DATA_W-1:0] scale_code(logic [ADC_W-1:0] code,
				logic [DATA_W-1:0] gain);
			logic [DATA_W-1:0] centred;
			centred = ({20'd0, code} << 12) - C_CENTRE;
			return qmul(centred, gain);
		endfunction

		function logic [DATA_W-1:0] track(logic [DATA_W-1:0] mean, logic [DATA_W-1:0] smp);
			logic [DATA_W-1:0] k;
			k = {7'd0, regs.avg_coeff};
			return qmul(mean, k) + qmul(smp, C_ONE - k);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				CFG_AVG_COEFF: regs.avg_coeff = data[COEF_W-1:0];
				CFG_GAIN_CUR_U: regs.gain_cur_u = data;
				CFG_GAIN_CUR_V: regs.gain_cur_v = data;
				CFG_GAIN_CUR_W: regs.gain_cur_w = data;
				CFG_GAIN_VOLT_AB: regs.gain_volt_ab = data;
				CFG_GAIN_VOLT_BC: regs.gain_volt_bc = data;
				CFG_GAIN_DC_BUS: regs.gain_dc_bus = data;
				CFG_OFFSET_DC_BUS: regs.offset_dc_bus = data;
				default: ;
			endcase
		endfunction

		function void note_sample(smp_t s);
			logic [DATA_W-1:0] iu, iv, iw, vab, vbc, two_mk, ia, ib;
			logic [DATA_W-1:0] dab, dbc, uu, uv, uw, ub, dc;
			logic [FLAG_N-1:0] fl;
			res_t r;
			iu = scale_code(s.adc_cur_u, regs.gain_cur_u);
			iv = scale_code(s.adc_cur_v, regs.gain_cur_v);
			iw = scale_code(s.adc_cur_w, regs.gain_cur_w);
			vab = scale_code(s.adc_volt_ab, regs.gain_volt_ab);
			vbc = scale_code(s.adc_volt_bc, regs.gain_volt_bc);

			// current path works on the updated means
			mean_iu = track(mean_iu, iu);
			mean_iv = track(mean_iv, iv);
			mean_iw = track(mean_iw, iw);
			two_mk = C_TWO - {7'd0, regs.avg_coeff};
			ia = qmul(two_mk, iu) - mean_iu;
			ib = qmul(ia + ((qmul(two_mk, iv) - mean_iv) << 1), C_INV_SQRT3);

			// voltage path works on the previous means
			dab = vab - mean_ab;
			dbc = vbc - mean_bc;
			uu = qmul(C_THIRD_NEG, (dab << 1) + dbc);
			uv = qmul(C_THIRD_POS, dab - dbc);
			uw = qmul(C_MINUS_ONE, uu + uv);
			mean_ab = track(mean_ab, vab);
			mean_bc = track(mean_bc, vbc);
			ub = qmul(uu + (uv << 1), C_INV_SQRT3);

			dc = qmul(({20'd0, s.adc_dc_bus} << 12) - regs.offset_dc_bus, regs.gain_dc_bus);

			fl = '0;
			if ($signed(dc) < s.dc_min_limit) fl[FB_DC_UNDER] = 1'b1;
			if ($signed(dc) > s.dc_max_limit) fl[FB_DC_OVER] = 1'b1;
			if (magnitude(uu) > longint'(s.ac_volt_limit)) fl[FB_VOLT_U] = 1'b1;
			if (magnitude(uv) > longint'(s.ac_volt_limit)) fl[FB_VOLT_V] = 1'b1;
			if (magnitude(uw) > longint'(s.ac_volt_limit)) fl[FB_VOLT_W] = 1'b1;
			if (magnitude(iu - mean_iu) >= longint'(s.ac_cur_limit)) fl[FB_CUR_U] = 1'b1;
			if (magnitude(iv - mean_iv) >= longint'(s.ac_cur_limit)) fl[FB_CUR_V] = 1'b1;
			if (magnitude(iw - mean_iw) >= longint'(s.ac_cur_limit)) fl[FB_CUR_W] = 1'b1;

			r.cur_alpha = ia;
			r.cur_beta = ib;
			r.volt_alpha = uu;
			r.volt_beta = ub;
			r.dc_bus_volt = dc;
			r.alarm_flags = fl;
			r.mean_cur_u_out = mean_iu;
			r.mean_cur_v_out = mean_iv;
			r.mean_cur_w_out = mean_iw;
			r.mean_volt_ab_out = mean_ab;
			r.mean_volt_bc_out = mean_bc;
			pending.push_back(r);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] expv,
				logic [DATA_W-1:0] actv);
			if (expv !== actv) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: %s mismatch: expected %h, got %h", $time, name, expv, actv);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result transaction with no sample pending", $time);
				return;
			end
			want = pending.pop_front();
			compare_field("cur_alpha", want.cur_alpha, got.cur_alpha);
			compare_field("cur_beta", want.cur_beta, got.cur_beta);
			compare_field("volt_alpha", want.volt_alpha, got.volt_alpha);
			compare_field("volt_beta", want.volt_beta, got.volt_beta);
			compare_field("dc_bus_volt", want.dc_bus_volt, got.dc_bus_volt);
			compare_field("alarm_flags", want.alarm_flags, got.alarm_flags);
			compare_field("mean_cur_u_out", want.mean_cur_u_out, got.mean_cur_u_out);
			compare_field("mean_cur_v_out", want.mean_cur_v_out, got.mean_cur_v_out);
			compare_field("mean_cur_w_out", want.mean_cur_w_out, got.mean_cur_w_out);
			compare_field("mean_volt_ab_out", want.mean_volt_ab_out, got.mean_volt_ab_out);
			compare_field("mean_volt_bc_out", want.mean_volt_bc_out, got.mean_volt_bc_out);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_wdata;

	mcc_in_if sample_ch();
	mcc_out_if result_ch();

	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_left;
	bit rx_hold_req;
	logic [ADC_W-1:0] code_base [6];

	conditioning_scoreboard sb = new();

	motor_adc_condition_clarke i_dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.sample(sample_ch),
		.result(result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left = HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.cur_alpha = result_ch.cur_alpha;
			got.cur_beta = result_ch.cur_beta;
			got.volt_alpha = result_ch.volt_alpha;
			got.volt_beta = result_ch.volt_beta;
			got.dc_bus_volt = result_ch.dc_bus_volt;
			got.alarm_flags = result_ch.alarm_flags;
			got.mean_cur_u_out = result_ch.mean_cur_u_out;
			got.mean_cur_v_out = result_ch.mean_cur_v_out;
			got.mean_cur_w_out = result_ch.mean_cur_w_out;
			got.mean_volt_ab_out = result_ch.mean_volt_ab_out;
			got.mean_volt_bc_out = result_ch.mean_volt_bc_out;
			sb.check_result(got);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_sample(input smp_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.adc_cur_u <= s.adc_cur_u;
		sample_ch.adc_cur_v <= s.adc_cur_v;
		sample_ch.adc_cur_w <= s.adc_cur_w;
		sample_ch.adc_volt_ab <= s.adc_volt_ab;
		sample_ch.adc_volt_bc <= s.adc_volt_bc;
		sample_ch.adc_dc_bus <= s.adc_dc_bus;
		sample_ch.dc_min_limit <= s.dc_min_limit;
		sample_ch.dc_max_limit <= s.dc_max_limit;
		sample_ch.ac_volt_limit <= s.ac_volt_limit;
		sample_ch.ac_cur_limit <= s.ac_cur_limit;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(s);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_config(input logic [DATA_W-1:0] coeff, gcu, gcv, gcw, gab, gbc,
			gdc, offs);
		write_reg(CFG_AVG_COEFF, coeff);
		write_reg(CFG_GAIN_CUR_U, gcu);
		write_reg(CFG_GAIN_CUR_V, gcv);
		write_reg(CFG_GAIN_CUR_W, gcw);
		write_reg(CFG_GAIN_VOLT_AB, gab);
		write_reg(CFG_GAIN_VOLT_BC, gbc);
		write_reg(CFG_GAIN_DC_BUS, gdc);
		write_reg(CFG_OFFSET_DC_BUS, offs);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending.size() != 0);
	endtask

	task automatic settle();
		wait_drained();
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	// mostly near a base code drawn once per phase, sometimes anywhere
	function automatic logic [ADC_W-1:0] pick_code(logic [ADC_W-1:0] base);
		int v;
		if ($urandom_range(3) == 0)
			return $urandom_range(0, CODE_MAX);
		v = int'(base) + int'($urandom_range(0, 128)) - 64;
		if (v < 0) v = 0;
		if (v > CODE_MAX) v = CODE_MAX;
		return v[ADC_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] pick_limit();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 24);
			2: return -$urandom_range(0, 1 << 24);
			3: return INT_MIN;
			4: return INT_MAX;
			default: return $urandom_range(0, 1 << 27);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] small_gain();
		return int'($urandom_range(0, 1 << 26)) - (1 << 25);
	endfunction

	task automatic run_directed();
		smp_t s;
		logic [ADC_W-1:0] pat [6];
		pat = '{12'h000, 12'hFFF, 12'h7FF, 12'h800, 12'hAAA, 12'h555};
		for (int n = 0; n < 24; n++) begin
			s.adc_cur_u = pat[n % 6];
			s.adc_cur_v = pat[(n + 1) % 6];
			s.adc_cur_w = pat[(n + 2) % 6];
			s.adc_volt_ab = pat[(n + 3) % 6];
			s.adc_volt_bc = pat[(n + 4) % 6];
			s.adc_dc_bus = pat[(n + 5) % 6];
			case (n % 4)
				0: begin
					s.dc_min_limit = INT_MIN;
					s.dc_max_limit = INT_MAX;
					s.ac_volt_limit = INT_MAX;
					s.ac_cur_limit = INT_MAX;
				end
				// every alarm raised
				1: begin
					s.dc_min_limit = INT_MAX;
					s.dc_max_limit = INT_MIN;
					s.ac_volt_limit = INT_MIN;
					s.ac_cur_limit = INT_MIN;
				end
				2: begin
					s.dc_min_limit = '0;
					s.dc_max_limit = '0;
					s.ac_volt_limit = '0;
					s.ac_cur_limit = '0;
				end
				default: begin
					s.dc_min_limit = 32'hAAAA_AAAA;
					s.dc_max_limit = 32'h5555_5555;
					s.ac_volt_limit = 32'h0055_5555;
					s.ac_cur_limit = 32'h00AA_AAAA;
				end
			endcase
			send_sample(s);
		end
	endtask

	task automatic run_phase(input int n_items, input bit hold_off);
		smp_t s;
		foreach (code_base[c]) code_base[c] = $urandom_range(0, CODE_MAX);
		for (int n = 0; n < n_items; n++) begin
			if (hold_off && n == n_items / 2) rx_hold_req = 1'b1;
			if (n == n_items / 3) wait_drained();
			s.adc_cur_u = pick_code(code_base[0]);
			s.adc_cur_v = pick_code(code_base[1]);
			s.adc_cur_w = pick_code(code_base[2]);
			s.adc_volt_ab = pick_code(code_base[3]);
			s.adc_volt_bc = pick_code(code_base[4]);
			s.adc_dc_bus = pick_code(code_base[5]);
			s.dc_min_limit = pick_limit();
			s.dc_max_limit = pick_limit();
			s.ac_volt_limit = pick_limit();
			s.ac_cur_limit = pick_limit();
			send_sample(s);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.adc_cur_u = '0;
		sample_ch.adc_cur_v = '0;
		sample_ch.adc_cur_w = '0;
		sample_ch.adc_volt_ab = '0;
		sample_ch.adc_volt_bc = '0;
		sample_ch.adc_dc_bus = '0;
		sample_ch.dc_min_limit = '0;
		sample_ch.dc_max_limit = '0;
		sample_ch.ac_volt_limit = '0;
		sample_ch.ac_cur_limit = '0;
		result_ch.ready = 1'b0;
		tx_idle_pct = 32;
		rx_idle_pct = 51;
		rx_hold_left = 0;
		rx_hold_req = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		settle();

		for (int ph = 1; ph <= 6; ph++) begin
			if (ph <= 2) begin
				tx_idle_pct = 32;
				rx_idle_pct = 51;
			end else if (ph <= 4) begin
				tx_idle_pct = 51;
				rx_idle_pct = 32;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (ph)
				1: apply_config(32'd0, C_TWO, C_MINUS_ONE, 32'd8388608, 32'd20000000,
					32'hFE80_0000, C_ONE, 32'h0080_0000);
				2: apply_config(C_ONE, INT_MAX, INT_MIN, INT_MAX, INT_MIN, INT_MAX, INT_MIN,
					INT_MIN);
				// coefficient masked to 25 bits, above 1.0
				3: apply_config(32'hFFFF_FFFF, INT_MIN, INT_MAX, 32'd0, 32'hFFFF_FFFF, 32'd1,
					INT_MAX, INT_MAX);
				4: apply_config($urandom_range(0, C_ONE), small_gain(), small_gain(),
					small_gain(), small_gain(), small_gain(), small_gain(), $urandom);
				5: apply_config({7'd0, AVG_COEFF_RST}, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE,
					C_ONE, 32'd0);
				default: apply_config($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			endcase
			run_phase(PHASE_ITEMS, ph == 5);
			settle();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== motor_adc_condition_clarke.f =====
rtl/mcc_pkg.sv
rtl/mcc_in_if.sv
rtl/mcc_out_if.sv
rtl/mcc_ucode.sv
rtl/mcc_datapath.sv
rtl/motor_adc_condition_clarke.sv
verif/testbench.sv
